### sv/psd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

  // The window end is limited to this record length.
  localparam int RecordLen = 256;

  localparam int SampleW = 32;
  localparam int IndexW  = 9;
  localparam int CountW  = 9;
  localparam int LenW    = 8;
  localparam int KindW   = 3;
  localparam int CfgIdxW = 3;

  localparam logic [IndexW-1:0] IndexMax = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    PhSearch = 2'd0,
    PhRun    = 2'd1,
    PhDone   = 2'd2
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KindLoss      = 3'd0,
    KindStill     = 3'd1,
    KindPulseUp   = 3'd2,
    KindPulseDown = 3'd3,
    KindStageUp   = 3'd4,
    KindStageDown = 3'd5
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegUpThr     = 3'd0,
    RegUpContThr = 3'd1,
    RegDnThr     = 3'd2,
    RegDnContThr = 3'd3,
    RegWinBegin  = 3'd4,
    RegWinEnd    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SampleW-1:0] up_thr;
    logic signed [SampleW-1:0] up_cont_thr;
    logic signed [SampleW-1:0] dn_thr;
    logic signed [SampleW-1:0] dn_cont_thr;
    logic        [7:0]         win_begin;
    logic        [8:0]         win_end;
  } cfg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [LenW-1:0]  run_length;
  } result_t;

endpackage

`default_nettype wire

### sv/psd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface psd_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [psd_pkg::SampleW-1:0]  sample;
  logic                                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface psd_result_if;
  logic                              valid;
  logic                              ready;
  logic [psd_pkg::KindW-1:0]         kind;
  logic [psd_pkg::LenW-1:0]          run_length;

  modport source (output valid, output kind, output run_length, input ready);
  modport sink   (input valid, input kind, input run_length, output ready);
endinterface

interface psd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [psd_pkg::CfgIdxW-1:0]       index;
  logic [psd_pkg::SampleW-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/pulse_step_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// Classifies one record of samples as loss, still, pulse or stage. Samples
// enter one per cycle with no gaps needed between them; a record ends with an
// item whose last flag is set, and its verdict is valid on the result channel
// once that item leaves the input register and the verdict is registered into
// the result slot. Throughput is one sample per cycle, set by the difference,
// threshold compare and run update done combinationally in the core; a held
// result stalls the input only when the next last item reaches the core.
// Registers are written through the configuration channel, always ready; the
// user must write them between records, as the block does not enforce it.
module pulse_step_detector (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  psd_cfg_if.sink       cfg_i,
  psd_sample_if.sink    in_i,
  psd_result_if.source  out_o
);

  psd_pkg::cfg_t    cfg_q;
  psd_pkg::item_t   item_q;
  logic             item_valid_q;
  psd_pkg::result_t res_q;
  logic             res_valid_q;
  psd_pkg::result_t core_res;
  logic             proc_fire;
  logic             in_fire;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_thr      <= '0;
      cfg_q.up_cont_thr <= '0;
      cfg_q.dn_thr      <= '0;
      cfg_q.dn_cont_thr <= '0;
      cfg_q.win_begin   <= 8'd1;
      cfg_q.win_end     <= 9'd256;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        psd_pkg::RegUpThr:     cfg_q.up_thr      <= cfg_i.data;
        psd_pkg::RegUpContThr: cfg_q.up_cont_thr <= cfg_i.data;
        psd_pkg::RegDnThr:     cfg_q.dn_thr      <= cfg_i.data;
        psd_pkg::RegDnContThr: cfg_q.dn_cont_thr <= cfg_i.data;
        psd_pkg::RegWinBegin:  cfg_q.win_begin   <= cfg_i.data[7:0];
        psd_pkg::RegWinEnd:    cfg_q.win_end     <= cfg_i.data[8:0];
        default: ;
      endcase
    end
  end

  // A last item may only advance when the result slot is free or being taken
  assign proc_fire   = item_valid_q && (!item_q.last || !res_valid_q || out_o.ready);
  assign in_i.ready  = !item_valid_q || proc_fire;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.sample <= in_i.sample;
      item_q.last   <= in_i.last;
    end
  end

  psd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .fire_i   (proc_fire),
    .item_i   (item_q),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (proc_fire && item_q.last) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && item_q.last) begin
      res_q <= core_res;
    end
  end

  assign out_o.valid      = res_valid_q;
  assign out_o.kind       = res_q.kind;
  assign out_o.run_length = res_q.run_length;

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(proc_fire && item_q.last))
    else $error("result appeared without a last item");

  a_no_result_mid_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && !item_q.last && !res_valid_q) |=> !res_valid_q)
    else $error("result appeared in the middle of a record");

  a_last_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && item_q.last && res_valid_q && !out_o.ready) |=>
      (item_valid_q && item_q.last))
    else $error("last item dropped while result stalled");

endmodule

`default_nettype wire

### sv/psd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module psd_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire psd_pkg::cfg_t    cfg_i,
  input  wire logic             fire_i,
  input  wire psd_pkg::item_t   item_i,
  output psd_pkg::result_t      result_o
);

  localparam logic [12:0] RecordLenW = 13'(psd_pkg::RecordLen);

  logic [psd_pkg::IndexW-1:0]        idx_q, idx_d;
  logic signed [psd_pkg::SampleW-1:0] prev_q, prev_d;
  logic                              loss_q, loss_d;
  psd_pkg::phase_e                   phase_q, phase_d;
  logic                              down_q, down_d;
  logic [psd_pkg::CountW-1:0]        count_q, count_d;
  psd_pkg::kind_e                    decided_q, decided_d;

  logic [8:0]         win_b;
  logic [8:0]         win_e;
  logic [9:0]         idx_p1;
  logic               idx_ok;
  logic signed [32:0] diff;
  logic               cont;
  psd_pkg::phase_e    phase_mid;
  logic               down_mid;
  logic [psd_pkg::CountW-1:0] count_mid;
  logic               loss_mid;
  psd_pkg::kind_e     kind_out;
  logic [psd_pkg::CountW-1:0] len_full;

  always_comb begin
    win_b  = (cfg_i.win_begin == 8'd0) ? 9'd1 : {1'b0, cfg_i.win_begin};
    win_e  = ({4'd0, cfg_i.win_end} < RecordLenW) ? cfg_i.win_end : RecordLenW[8:0];
    idx_ok = (idx_q != psd_pkg::IndexMax);
    idx_p1 = {1'b0, idx_q} + 10'd1;
    diff   = {item_i.sample[31], item_i.sample} - {prev_q[31], prev_q};

    loss_mid = loss_q;
    if (idx_ok && idx_p1 >= {1'b0, win_b} && idx_p1 <= {1'b0, win_e}
        && item_i.sample == -32'sd1) begin
      loss_mid = 1'b1;
    end

    phase_mid = phase_q;
    down_mid  = down_q;
    count_mid = count_q;
    decided_d = decided_q;
    cont      = 1'b0;

    if (idx_ok && idx_q >= win_b && idx_q < win_e && phase_q != psd_pkg::PhDone) begin
      // Open a run on the first difference past its start threshold
      if (phase_q == psd_pkg::PhSearch) begin
        if (diff > 33'sd0) begin
          if (diff > 33'(cfg_i.up_thr)) begin
            phase_mid = psd_pkg::PhRun;
            down_mid  = 1'b0;
            count_mid = '0;
          end
        end else if (diff < 33'(cfg_i.dn_thr)) begin
          phase_mid = psd_pkg::PhRun;
          down_mid  = 1'b1;
          count_mid = '0;
        end
      end
      if (phase_mid == psd_pkg::PhRun) begin
        cont = down_mid ? (diff < 33'(cfg_i.dn_cont_thr))
                        : (diff > 33'(cfg_i.up_cont_thr));
        if (cont) begin
          if (count_mid != psd_pkg::CountMax) begin
            count_mid = count_mid + 1'b1;
          end
          if (idx_p1 >= {1'b0, win_e}) begin
            phase_mid = psd_pkg::PhDone;
            decided_d = down_mid ? psd_pkg::KindStageDown : psd_pkg::KindStageUp;
          end
        end else begin
          phase_mid = psd_pkg::PhDone;
          decided_d = down_mid ? psd_pkg::KindPulseDown : psd_pkg::KindPulseUp;
        end
      end
    end

    // Verdict for the record, used when this item is the last one
    len_full = '0;
    if (loss_mid) begin
      kind_out = psd_pkg::KindLoss;
    end else begin
      unique case (phase_mid)
        psd_pkg::PhSearch: kind_out = psd_pkg::KindStill;
        psd_pkg::PhRun: begin
          kind_out = down_mid ? psd_pkg::KindPulseDown : psd_pkg::KindPulseUp;
          len_full = count_mid;
        end
        default: begin
          kind_out = decided_d;
          if (decided_d == psd_pkg::KindPulseUp || decided_d == psd_pkg::KindPulseDown) begin
            len_full = count_mid;
          end
        end
      endcase
    end
    result_o.kind       = kind_out;
    result_o.run_length = (len_full > 9'd255) ? 8'd255 : len_full[7:0];

    if (item_i.last) begin
      idx_d     = '0;
      prev_d    = '0;
      loss_d    = 1'b0;
      phase_d   = psd_pkg::PhSearch;
      down_d    = 1'b0;
      count_d   = '0;
      decided_d = psd_pkg::KindStill;
    end else begin
      idx_d   = idx_ok ? idx_p1[8:0] : idx_q;
      prev_d  = item_i.sample;
      loss_d  = loss_mid;
      phase_d = phase_mid;
      down_d  = down_mid;
      count_d = count_mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      prev_q    <= '0;
      loss_q    <= 1'b0;
      phase_q   <= psd_pkg::PhSearch;
      down_q    <= 1'b0;
      count_q   <= '0;
      decided_q <= psd_pkg::KindStill;
    end else if (fire_i) begin
      idx_q     <= idx_d;
      prev_q    <= prev_d;
      loss_q    <= loss_d;
      phase_q   <= phase_d;
      down_q    <= down_d;
      count_q   <= count_d;
      decided_q <= decided_d;
    end
  end

endmodule

`default_nettype wire

### dv/psd_verdict_checker.sv
`timescale 1ns / 1ps

module psd_verdict_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_ready_i,
  input  wire logic [psd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [psd_pkg::SampleW-1:0] cfg_data_i,
  input  wire logic                        smp_valid_i,
  input  wire logic                        smp_ready_i,
  input  wire logic [psd_pkg::SampleW-1:0] smp_sample_i,
  input  wire logic                        smp_last_i,
  input  wire logic                        res_valid_i,
  input  wire logic                        res_ready_i,
  input  wire logic [psd_pkg::KindW-1:0]   res_kind_i,
  input  wire logic [psd_pkg::LenW-1:0]    res_len_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  typedef struct {
    psd_pkg::kind_e           kind;
    logic [psd_pkg::LenW-1:0] run_length;
  } verdict_t;

  // register copies
  logic signed [psd_pkg::SampleW-1:0] up_thr;
  logic signed [psd_pkg::SampleW-1:0] up_cont_thr;
  logic signed [psd_pkg::SampleW-1:0] dn_thr;
  logic signed [psd_pkg::SampleW-1:0] dn_cont_thr;
  logic [7:0]                         win_begin;
  logic [8:0]                         win_end;

  // per-record scan state
  logic [psd_pkg::IndexW-1:0]         idx_q;
  logic signed [psd_pkg::SampleW-1:0] prev_q;
  logic                               lost_q;
  psd_pkg::phase_e                    phase_q;
  logic                               down_q;
  logic [psd_pkg::CountW-1:0]         count_q;
  psd_pkg::kind_e                     decided_q;

  verdict_t verdicts_due[$];
  verdict_t fresh;
  verdict_t oldest;
  int       errors;

  function automatic void clear_record();
    idx_q     = '0;
    prev_q    = '0;
    lost_q    = 1'b0;
    phase_q   = psd_pkg::PhSearch;
    down_q    = 1'b0;
    count_q   = '0;
    decided_q = psd_pkg::KindStill;
  endfunction

  function automatic bit absorb_sample(input logic signed [psd_pkg::SampleW-1:0] s,
                                       input logic last, output verdict_t v);
    int                               b;
    int                               e;
    int                               j;
    int                               len;
    logic signed [psd_pkg::SampleW:0] d;
    logic                             cont;
    b = (win_begin == '0) ? 1 : int'(win_begin);
    e = (int'(win_end) < psd_pkg::RecordLen) ? int'(win_end) : psd_pkg::RecordLen;
    j = int'(idx_q);
    v.kind = psd_pkg::KindStill;
    v.run_length = '0;
    // loss window starts one index below the first difference
    if (j < int'(psd_pkg::IndexMax) && j + 1 >= b && j + 1 <= e && s == -1) lost_q = 1'b1;
    if (j < int'(psd_pkg::IndexMax) && j >= b && j < e && phase_q != psd_pkg::PhDone) begin
      d = {s[psd_pkg::SampleW-1], s} - {prev_q[psd_pkg::SampleW-1], prev_q};
      if (phase_q == psd_pkg::PhSearch) begin
        if (d > 0) begin
          if (d > up_thr) begin
            phase_q = psd_pkg::PhRun;
            down_q  = 1'b0;
            count_q = '0;
          end
        end else if (d < dn_thr) begin
          phase_q = psd_pkg::PhRun;
          down_q  = 1'b1;
          count_q = '0;
        end
      end
      if (phase_q == psd_pkg::PhRun) begin
        cont = down_q ? (d < dn_cont_thr) : (d > up_cont_thr);
        if (cont) begin
          if (count_q != psd_pkg::CountMax) count_q = count_q + 1'b1;
          if (j + 1 >= e) begin
            phase_q = psd_pkg::PhDone;
            if (down_q) decided_q = psd_pkg::KindStageDown;
            else decided_q = psd_pkg::KindStageUp;
          end
        end else begin
          phase_q = psd_pkg::PhDone;
          if (down_q) decided_q = psd_pkg::KindPulseDown;
          else decided_q = psd_pkg::KindPulseUp;
        end
      end
    end
    prev_q = s;
    if (idx_q != psd_pkg::IndexMax) idx_q = idx_q + 1'b1;
    if (!last) return 1'b0;

    len = 0;
    if (lost_q) begin
      v.kind = psd_pkg::KindLoss;
    end else if (phase_q == psd_pkg::PhSearch) begin
      v.kind = psd_pkg::KindStill;
    end else if (phase_q == psd_pkg::PhRun) begin
      // record ended with the run still open
      if (down_q) v.kind = psd_pkg::KindPulseDown;
      else v.kind = psd_pkg::KindPulseUp;
      len = int'(count_q);
    end else begin
      v.kind = decided_q;
      if (decided_q == psd_pkg::KindPulseUp || decided_q == psd_pkg::KindPulseDown) begin
        len = int'(count_q);
      end
    end
    if (len > 255) len = 255;
    v.run_length = psd_pkg::LenW'(len);
    clear_record();
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_thr      = '0;
      up_cont_thr = '0;
      dn_thr      = '0;
      dn_cont_thr = '0;
      win_begin   = 8'd1;
      win_end     = 9'd256;
      clear_record();
      verdicts_due.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          psd_pkg::RegUpThr:     up_thr      = cfg_data_i;
          psd_pkg::RegUpContThr: up_cont_thr = cfg_data_i;
          psd_pkg::RegDnThr:     dn_thr      = cfg_data_i;
          psd_pkg::RegDnContThr: dn_cont_thr = cfg_data_i;
          psd_pkg::RegWinBegin:  win_begin   = cfg_data_i[7:0];
          psd_pkg::RegWinEnd:    win_end     = cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (smp_valid_i && smp_ready_i) begin
        if (absorb_sample(smp_sample_i, smp_last_i, fresh)) verdicts_due.push_back(fresh);
      end
      if (res_valid_i && res_ready_i) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result kind %0d length %0d, expected none",
                   $time, res_kind_i, res_len_i);
          errors++;
        end else begin
          oldest = verdicts_due.pop_front();
          if (res_kind_i !== oldest.kind) begin
            $display("%0t: kind mismatch, expected %0d, actual %0d",
                     $time, oldest.kind, res_kind_i);
            errors++;
          end
          if (res_len_i !== oldest.run_length) begin
            $display("%0t: run length mismatch, expected %0d, actual %0d",
                     $time, oldest.run_length, res_len_i);
            errors++;
          end
        end
      end
      fail_count_o <= errors;
      pending_o    <= verdicts_due.size();
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int HoldCycles = 300;
  localparam int StallLimit = 2000;
  localparam int Latency    = 2;
  localparam int ItemTarget = 1450;
  localparam int CalmItems  = 250;
  localparam int HoldPhase  = 3;
  localparam int LongPhase  = 6;
  localparam int LongRecord = 520;

  // indexes that map to no register
  localparam logic [psd_pkg::CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [psd_pkg::CfgIdxW-1:0] RegSpareHi = 3'd7;

  localparam longint SampleHi = 64'sh7FFF_FFFF;
  localparam longint SampleLo = -64'sh8000_0000;

  logic clk_i;
  logic rst_ni;

  psd_cfg_if    cfg_bus ();
  psd_sample_if smp_bus ();
  psd_result_if res_bus ();

  int fail_count;
  int pending;
  int items_sent;
  int idle_odds;
  int hold_seq;
  int hold_seen;
  int quiet_cycles;

  // register values as last written, used to shape records
  logic signed [psd_pkg::SampleW-1:0] up_c;
  logic signed [psd_pkg::SampleW-1:0] upc_c;
  logic signed [psd_pkg::SampleW-1:0] dn_c;
  logic signed [psd_pkg::SampleW-1:0] dnc_c;
  logic [7:0]                         wb_c;
  logic [8:0]                         we_c;

  pulse_step_detector dut (
    .clk_i,
    .rst_ni,
    .cfg_i (cfg_bus),
    .in_i  (smp_bus),
    .out_o (res_bus)
  );

  psd_verdict_checker chk (
    .clk_i,
    .rst_ni,
    .cfg_valid_i  (cfg_bus.valid),
    .cfg_ready_i  (cfg_bus.ready),
    .cfg_index_i  (cfg_bus.index),
    .cfg_data_i   (cfg_bus.data),
    .smp_valid_i  (smp_bus.valid),
    .smp_ready_i  (smp_bus.ready),
    .smp_sample_i (smp_bus.sample),
    .smp_last_i   (smp_bus.last),
    .res_valid_i  (res_bus.valid),
    .res_ready_i  (res_bus.ready),
    .res_kind_i   (res_bus.kind),
    .res_len_i    (res_bus.run_length),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int roll(input int hi);
    return int'($urandom_range(0, hi));
  endfunction

  function automatic logic [psd_pkg::SampleW-1:0] pick_threshold();
    case (roll(9))
      0:          return 32'h7FFF_FFFF;
      1:          return 32'h8000_0000;
      2, 3, 4, 5: return psd_pkg::SampleW'(roll(20) - 10);
      6, 7:       return psd_pkg::SampleW'(roll(2000) - 1000);
      default:    return $urandom;
    endcase
  endfunction

  task automatic push_sample(input logic signed [psd_pkg::SampleW-1:0] s, input logic last);
    // no idling once the run is in its calm tail
    if (idle_odds != 0 && items_sent < ItemTarget - CalmItems &&
        roll(idle_odds - 1) == 0) begin
      smp_bus.valid <= 1'b0;
      repeat (1 + roll(13)) @(posedge clk_i);
    end
    smp_bus.valid  <= 1'b1;
    smp_bus.sample <= s;
    smp_bus.last   <= last;
    do @(posedge clk_i); while (!smp_bus.ready);
    items_sent++;
  endtask

  task automatic write_reg(input logic [psd_pkg::CfgIdxW-1:0] idx,
                           input logic [psd_pkg::SampleW-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      psd_pkg::RegUpThr:     up_c  = val;
      psd_pkg::RegUpContThr: upc_c = val;
      psd_pkg::RegDnThr:     dn_c  = val;
      psd_pkg::RegDnContThr: dnc_c = val;
      psd_pkg::RegWinBegin:  wb_c  = val[7:0];
      psd_pkg::RegWinEnd:    we_c  = val[8:0];
      default: ;
    endcase
  endtask

  task automatic end_cfg();
    cfg_bus.valid <= 1'b0;
  endtask

  // Drop the input, wait for every verdict, then let the core go quiet.
  task automatic settle();
    smp_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic send_record(input int n);
    int                                 eb;
    int                                 ee;
    int                                 k;
    int                                 m;
    int                                 lost_at;
    int                                 style;
    int                                 i;
    bit                                 up;
    longint                             prev;
    longint                             t;
    longint                             d;
    logic signed [psd_pkg::SampleW-1:0] s;
    eb = (wb_c == '0) ? 1 : int'(wb_c);
    ee = (int'(we_c) < psd_pkg::RecordLen) ? int'(we_c) : psd_pkg::RecordLen;
    style = roll(9);
    up = roll(1);
    k = eb + roll(((ee > eb) ? ee - eb : 0) + 1);
    m = (roll(3) == 0) ? roll(ee) : roll(6);
    case (roll(7))
      0:       lost_at = roll(n - 1);
      1:       lost_at = eb - 2;
      2:       lost_at = eb - 1;
      3:       lost_at = ee - 1;
      4:       lost_at = ee;
      default: lost_at = -1;
    endcase
    prev = 0;
    for (i = 0; i < n; i++) begin
      if (style == 0 || (i == 0 && roll(1) == 0)) begin
        t = longint'($signed($urandom));
      end else if (i == 0) begin
        t = longint'(roll(2000) - 1000);
      end else begin
        // quiet lead-in, one opening difference, a run of passing ones, one that fails, then quiet
        if (i < k || i > k + m + 1) begin
          d = (roll(3) == 0) ? longint'(roll(2) - 1) : 0;
        end else if (i == k) begin
          if (up) d = ((up_c > 0) ? longint'(up_c) : 0) + 1 + roll(2);
          else d = ((dn_c < 1) ? longint'(dn_c) : 1) - 1 - roll(2);
        end else if (i <= k + m) begin
          if (up) d = longint'(upc_c) + 1 + roll(1);
          else d = longint'(dnc_c) - 1 - roll(1);
        end else begin
          if (up) d = longint'(upc_c) - roll(1);
          else d = longint'(dnc_c) + roll(1);
        end
        t = prev + d;
        if (t > SampleHi) t = SampleHi;
        if (t < SampleLo) t = SampleLo;
      end
      if (i == lost_at) t = -1;
      s = t[psd_pkg::SampleW-1:0];
      push_sample(s, i == n - 1);
      prev = longint'(s);
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    res_bus.ready = 1'b0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        res_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        res_bus.ready <= 1'b1;
      end else if (idle_odds != 0 && items_sent < ItemTarget - CalmItems &&
                   roll(idle_odds - 1) == 0) begin
        res_bus.ready <= 1'b0;
        repeat (1 + roll(13)) @(posedge clk_i);
        res_bus.ready <= 1'b1;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((smp_bus.valid && smp_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int phase_no;
    int nrec;
    int n;
    int ee;
    int wb;
    int we;
    rst_ni         = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = '0;
    cfg_bus.data   = '0;
    smp_bus.valid  = 1'b0;
    smp_bus.sample = '0;
    smp_bus.last   = 1'b0;
    idle_odds      = 0;
    hold_seq       = 0;
    items_sent     = 0;
    up_c  = '0;
    upc_c = '0;
    dn_c  = '0;
    dnc_c = '0;
    wb_c  = 8'd1;
    we_c  = 9'd256;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lost sample at index zero
    push_sample(-1, 1'b1);
    // short upward run cut off by the end of the record
    push_sample(0, 1'b0);
    push_sample(5, 1'b1);
    // downward pulse of two
    push_sample(0, 1'b0);
    push_sample(-3, 1'b0);
    push_sample(-6, 1'b0);
    push_sample(-6, 1'b1);
    settle();

    // widest rise against the largest threshold, zero begin, run reaching the window end
    write_reg(psd_pkg::RegUpThr, 32'h7FFF_FFFF);
    write_reg(psd_pkg::RegWinBegin, 32'd0);
    write_reg(psd_pkg::RegWinEnd, 32'd2);
    end_cfg();
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b1);
    settle();
    write_reg(psd_pkg::RegDnThr, 32'h8000_0000);
    end_cfg();
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h8000_0000, 1'b1);
    settle();

    // empty window hides a lost sample
    write_reg(psd_pkg::RegWinBegin, 32'd3);
    write_reg(psd_pkg::RegWinEnd, 32'd2);
    end_cfg();
    push_sample(0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(-1, 1'b1);
    settle();

    // opening difference fails continuation; end beyond the record
    write_reg(psd_pkg::RegUpThr, 32'd0);
    write_reg(psd_pkg::RegDnThr, 32'd0);
    write_reg(psd_pkg::RegUpContThr, 32'd100);
    write_reg(psd_pkg::RegDnContThr, 32'h7FFF_FFFF);
    write_reg(psd_pkg::RegWinBegin, 32'd1);
    write_reg(psd_pkg::RegWinEnd, 32'd300);
    end_cfg();
    push_sample(0, 1'b0);
    push_sample(5, 1'b0);
    push_sample(5, 1'b1);
    // single-sample record ends during the search
    push_sample(7, 1'b1);

    phase_no = 0;
    while (items_sent < ItemTarget) begin
      phase_no++;
      settle();
      write_reg(psd_pkg::RegUpThr, pick_threshold());
      write_reg(psd_pkg::RegUpContThr, pick_threshold());
      write_reg(psd_pkg::RegDnThr, pick_threshold());
      write_reg(psd_pkg::RegDnContThr, pick_threshold());
      case (roll(7))
        0:       wb = 0;
        1:       wb = 255;
        2:       wb = roll(255);
        default: wb = roll(12);
      endcase
      write_reg(psd_pkg::RegWinBegin, psd_pkg::SampleW'(wb));
      case (roll(9))
        0:       we = 256;
        1:       we = 257 + roll(254);
        2:       we = roll(511);
        default: we = ((wb == 0) ? 1 : wb) + roll(30);
      endcase
      if (we > 511) we = 511;
      write_reg(psd_pkg::RegWinEnd, psd_pkg::SampleW'(we));
      if (roll(3) == 0) write_reg(roll(1) ? RegSpareHi : RegSpareLo, $urandom);
      end_cfg();

      if (items_sent > ItemTarget - CalmItems) begin
        idle_odds <= 0;
      end else begin
        case (roll(3))
          0:       idle_odds <= 0;
          1:       idle_odds <= 3;
          2:       idle_odds <= 6;
          default: idle_odds <= 10;
        endcase
      end

      ee = (int'(we_c) < psd_pkg::RecordLen) ? int'(we_c) : psd_pkg::RecordLen;
      if (phase_no == HoldPhase) begin
        // hold the result side while short records keep coming
        hold_seq <= hold_seq + 1;
        nrec = 10;
      end else if (phase_no == LongPhase) begin
        nrec = 1;
      end else begin
        nrec = (ee > 48) ? 1 : 3 + roll(5);
      end
      for (int r = 0; r < nrec; r++) begin
        if (phase_no == HoldPhase) begin
          n = 2 + roll(6);
        end else if (phase_no == LongPhase) begin
          n = LongRecord;
        end else begin
          n = ee + roll(3);
          if (roll(3) == 0) n = 1 + roll(ee + 2);
        end
        send_record(n);
      end
    end

    settle();
    repeat (Latency + 6) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
